// ----- rtl/wht_pkg.sv -----
// Shared types, constants and command/status structs of the thermostat controller.
package wht_pkg;

  // Ring of averaged temperature samples
  localparam int SAMPLES = 10;
  localparam int IDX_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W   = 8 + $clog2(SAMPLES);

  // Reciprocal used for the ring average: q = (sum * RECIP) >> RECIP_SH, then one fix-up
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / SAMPLES;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // Timing and control constants
  localparam int TICKS_PER_SEC = 10;
  localparam int IDLE_SAVE_SEC = 5;
  localparam int SET_STEP      = 5;
  localparam int BAND          = 5;
  localparam int ADC_SCALE     = 125;

  // Register reset values
  localparam logic [6:0] MIN_SET_RESET  = 7'd35;
  localparam logic [6:0] MAX_SET_RESET  = 7'd75;
  localparam logic [6:0] INIT_SET_RESET = 7'd60;

  // Register indexes
  localparam logic [1:0] CFG_MIN_SET  = 2'd0;
  localparam logic [1:0] CFG_MAX_SET  = 2'd1;
  localparam logic [1:0] CFG_INIT_SET = 2'd2;

  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_WAKE  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_OPER  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_TICK  = 2'd0,
    EV_UP    = 2'd1,
    EV_DOWN  = 2'd2,
    EV_POWER = 2'd3
  } event_e;

  typedef struct packed {
    logic             evt_load;
    logic             sum_clr;
    logic             sum_step;
    logic [IDX_W-1:0] sum_idx;
    logic             div_mul;
    logic             div_fix;
    logic             ctrl_apply;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic oper;
    logic avg_due;
  } status_t;

endpackage

// ----- rtl/wht_if.sv -----
// Request channels of the thermostat controller: event input, result output, register write.
interface wht_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [9:0] adc_sample;
  modport source (output valid, output event_kind, output adc_sample, input ready);
  modport sink (input valid, input event_kind, input adc_sample, output ready);
endinterface

interface wht_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic       heater_on;
  logic       cooler_on;
  logic       led_on;
  logic       display_on;
  logic [7:0] display_value;
  logic [6:0] saved_temp;
  modport source (output valid, output mode_now, output heater_on, output cooler_on,
                  output led_on, output display_on, output display_value,
                  output saved_temp, input ready);
  modport sink (input valid, input mode_now, input heater_on, input cooler_on,
                input led_on, input display_on, input display_value,
                input saved_temp, output ready);
endinterface

interface wht_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/water_heater_thermostat_controller.sv -----
// Water heater thermostat controller: top level joining sequencer and datapath.
//
// One event request (tick with converter sample, up, down or power press) yields one
// result request carrying mode, drive bits, display state and the saved set point.
// An event that leaves the controller outside operating mode goes from acceptance through
// dispatch straight to the result register, an operating-mode event adds the control step,
// and one that leaves the ring index on the last entry first sums the ring, walking it
// one entry per cycle through a single adder, then does a reciprocal multiply and one
// correction step. A new event is accepted as soon as the previous result sits in the
// output register. Register writes are taken every cycle and are expected only while
// no event is in flight.
module water_heater_thermostat_controller (
  input logic        clk_i,
  input logic        rst_ni,
  wht_in_if.sink     in_i,
  wht_out_if.source  out_o,
  wht_cfg_if.sink    cfg_i
);

  wht_pkg::cmd_t    cmd;
  wht_pkg::status_t sts;

  assign cfg_i.ready = 1'b1;

  wht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wht_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .event_kind_i    (in_i.event_kind),
    .adc_sample_i    (in_i.adc_sample),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_now_o      (out_o.mode_now),
    .heater_on_o     (out_o.heater_on),
    .cooler_on_o     (out_o.cooler_on),
    .led_on_o        (out_o.led_on),
    .display_on_o    (out_o.display_on),
    .display_value_o (out_o.display_value),
    .saved_temp_o    (out_o.saved_temp)
  );

endmodule

// ----- rtl/wht_datapath.sv -----
// Thermostat state, event update, sample ring, averaging arithmetic and result register.
module wht_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       event_kind_i,
  input  logic [9:0]       adc_sample_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [6:0]       cfg_data_i,
  input  wht_pkg::cmd_t    cmd_i,
  output wht_pkg::status_t sts_o,
  output logic [1:0]       mode_now_o,
  output logic             heater_on_o,
  output logic             cooler_on_o,
  output logic             led_on_o,
  output logic             display_on_o,
  output logic [7:0]       display_value_o,
  output logic [6:0]       saved_temp_o
);

  localparam int IW = wht_pkg::IDX_W;
  localparam int SW = wht_pkg::SUM_W;
  localparam int PW = wht_pkg::PROD_W;

  logic [6:0]          min_q, min_d, max_q, max_d;
  logic                power_q, power_d;
  wht_pkg::mode_e      mode_q, mode_d;
  logic [6:0]          set_q, set_d, stored_q, stored_d;
  logic [3:0]          tick_q, tick_d;
  logic [2:0]          idle_q, idle_d;
  logic                blink_q, blink_d;
  logic [7:0]          ring_q [wht_pkg::SAMPLES];
  logic [IW-1:0]       ring_index_q, ring_index_d;
  logic [7:0]          avg_q, avg_d;
  logic                filled_q, filled_d;
  logic [7:0]          latest_q, latest_d;
  logic                heat_q, heat_d, cool_q, cool_d, lamp_q, lamp_d;
  logic [SW-1:0]       acc_q;
  logic [PW-1:0]       prod_q;

  logic                ring_we;
  logic [IW-1:0]       ring_widx;
  logic [16:0]         scaled;
  logic [8:0]          temp_raw;
  logic [7:0]          temp_sat;
  logic                second;
  logic [2:0]          idle_inc;
  logic [7:0]          up_sum, dn_lim;
  logic [6:0]          up_val, dn_val;
  logic [7:0]          q0;
  logic [SW-1:0]       rem;
  logic [8:0]          set_hi, avg_hi;
  wht_pkg::event_e     ev;

  assign ev       = wht_pkg::event_e'(event_kind_i);
  assign scaled   = 17'(adc_sample_i) * 17'(wht_pkg::ADC_SCALE);
  assign temp_raw = scaled[16:8];
  assign temp_sat = (temp_raw > 9'd255) ? 8'hFF : temp_raw[7:0];
  assign second   = (tick_q == 4'(wht_pkg::TICKS_PER_SEC - 1));
  assign idle_inc = idle_q + 3'd1;

  assign up_sum = {1'b0, set_q} + 8'(wht_pkg::SET_STEP);
  assign up_val = (up_sum > {1'b0, max_q}) ? max_q : up_sum[6:0];
  assign dn_lim = {1'b0, min_q} + 8'(wht_pkg::SET_STEP);
  assign dn_val = ({1'b0, set_q} < dn_lim) ? min_q : set_q - 7'(wht_pkg::SET_STEP);

  assign q0  = prod_q[wht_pkg::RECIP_SH +: 8];
  assign rem = acc_q - SW'(q0) * SW'(wht_pkg::SAMPLES);

  assign set_hi = {2'b0, set_q} + 9'(wht_pkg::BAND);
  assign avg_hi = {1'b0, avg_q} + 9'(wht_pkg::BAND);

  assign sts_o.oper    = (mode_q == wht_pkg::MODE_OPER);
  assign sts_o.avg_due = (ring_index_q == IW'(wht_pkg::SAMPLES - 1));

  always_comb begin
    min_d        = min_q;
    max_d        = max_q;
    power_d      = power_q;
    mode_d       = mode_q;
    set_d        = set_q;
    stored_d     = stored_q;
    tick_d       = tick_q;
    idle_d       = idle_q;
    blink_d      = blink_q;
    ring_index_d = ring_index_q;
    avg_d        = avg_q;
    filled_d     = filled_q;
    latest_d     = latest_q;
    heat_d       = heat_q;
    cool_d       = cool_q;
    lamp_d       = lamp_q;
    ring_we      = 1'b0;
    ring_widx    = ring_index_q;

    if (cmd_i.evt_load) begin
      case (ev)
        wht_pkg::EV_TICK: begin
          if (mode_q == wht_pkg::MODE_SET || mode_q == wht_pkg::MODE_OPER) begin
            tick_d = second ? 4'd0 : tick_q + 4'd1;
            if (mode_q == wht_pkg::MODE_OPER) begin
              latest_d = temp_sat;
              if ((IW + 1)'(ring_index_q) >= (IW + 1)'(wht_pkg::SAMPLES)) begin
                ring_widx = '0;
              end
              ring_we      = 1'b1;
              ring_index_d = (ring_widx == IW'(wht_pkg::SAMPLES - 1)) ? '0
                                                                     : ring_widx + IW'(1);
              if (second) begin
                if (heat_q) begin
                  lamp_d = ~lamp_q;
                end else if (cool_q) begin
                  lamp_d = 1'b1;
                end
              end
            end else if (second) begin
              blink_d = ~blink_q;
              idle_d  = idle_inc;
              if (idle_inc == 3'(wht_pkg::IDLE_SAVE_SEC)) begin
                stored_d = set_q;
                idle_d   = 3'd0;
                mode_d   = wht_pkg::MODE_OPER;
              end
            end
          end
        end
        wht_pkg::EV_POWER: begin
          if (mode_q == wht_pkg::MODE_SET) begin
            stored_d = set_q;
          end
          if (power_q) begin
            power_d = 1'b0;
            mode_d  = wht_pkg::MODE_SLEEP;
            heat_d  = 1'b0;
            cool_d  = 1'b0;
            lamp_d  = 1'b0;
          end else begin
            power_d = 1'b1;
            mode_d  = wht_pkg::MODE_WAKE;
            set_d   = (mode_q == wht_pkg::MODE_SET) ? set_q : stored_q;
          end
        end
        default: begin
          if (mode_q == wht_pkg::MODE_WAKE || mode_q == wht_pkg::MODE_OPER) begin
            idle_d = 3'd0;
            heat_d = 1'b0;
            cool_d = 1'b0;
            lamp_d = 1'b0;
            mode_d = wht_pkg::MODE_SET;
          end else if (mode_q == wht_pkg::MODE_SET) begin
            if (ev == wht_pkg::EV_UP) begin
              if (set_q < max_q) begin
                set_d  = up_val;
                idle_d = 3'd0;
              end
            end else if (set_q > min_q) begin
              set_d  = dn_val;
              idle_d = 3'd0;
            end
          end
        end
      endcase
    end

    // round the reciprocal estimate up when one divisor still fits in the remainder
    if (cmd_i.div_fix) begin
      avg_d    = (rem >= SW'(wht_pkg::SAMPLES)) ? q0 + 8'd1 : q0;
      filled_d = 1'b1;
    end

    if (cmd_i.ctrl_apply && filled_q) begin
      if ({1'b0, avg_q} >= set_hi) begin
        heat_d = 1'b0;
        cool_d = 1'b1;
      end else if (avg_hi <= {2'b0, set_q}) begin
        heat_d = 1'b1;
        cool_d = 1'b0;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        wht_pkg::CFG_MIN_SET:  min_d = cfg_data_i;
        wht_pkg::CFG_MAX_SET:  max_d = cfg_data_i;
        wht_pkg::CFG_INIT_SET: begin
          stored_d = cfg_data_i;
          set_d    = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= wht_pkg::MIN_SET_RESET;
      max_q        <= wht_pkg::MAX_SET_RESET;
      power_q      <= 1'b0;
      mode_q       <= wht_pkg::MODE_SLEEP;
      set_q        <= wht_pkg::INIT_SET_RESET;
      stored_q     <= wht_pkg::INIT_SET_RESET;
      tick_q       <= 4'd0;
      idle_q       <= 3'd0;
      blink_q      <= 1'b0;
      ring_index_q <= '0;
      avg_q        <= 8'd0;
      filled_q     <= 1'b0;
      latest_q     <= 8'd0;
      heat_q       <= 1'b0;
      cool_q       <= 1'b0;
      lamp_q       <= 1'b0;
      for (int i = 0; i < wht_pkg::SAMPLES; i++) begin
        ring_q[i] <= 8'd0;
      end
    end else begin
      min_q        <= min_d;
      max_q        <= max_d;
      power_q      <= power_d;
      mode_q       <= mode_d;
      set_q        <= set_d;
      stored_q     <= stored_d;
      tick_q       <= tick_d;
      idle_q       <= idle_d;
      blink_q      <= blink_d;
      ring_index_q <= ring_index_d;
      avg_q        <= avg_d;
      filled_q     <= filled_d;
      latest_q     <= latest_d;
      heat_q       <= heat_d;
      cool_q       <= cool_d;
      lamp_q       <= lamp_d;
      if (ring_we) begin
        ring_q[ring_widx] <= temp_sat;
      end
    end
  end

  // accumulate one ring entry per cycle, then multiply by the reciprocal
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step) begin
      acc_q <= acc_q + SW'(ring_q[cmd_i.sum_idx]);
    end
    if (cmd_i.div_mul) begin
      prod_q <= PW'(acc_q) * PW'(wht_pkg::RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mode_now_o      <= mode_q;
      heater_on_o     <= heat_q;
      cooler_on_o     <= cool_q;
      led_on_o        <= lamp_q;
      display_on_o    <= (mode_q == wht_pkg::MODE_SLEEP) ? 1'b0
                       : (mode_q == wht_pkg::MODE_SET)   ? blink_q : 1'b1;
      display_value_o <= (mode_q == wht_pkg::MODE_OPER) ? latest_q : {1'b0, set_q};
      saved_temp_o    <= stored_q;
    end
  end

  a_drive_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(heat_q && cool_q))
    else $error("heater and cooler both driven");

  a_sleep_drives_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == wht_pkg::MODE_SLEEP |-> !heat_q && !cool_q && !lamp_q)
    else $error("drive active in sleep");

  a_ring_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IW + 1)'(ring_index_q) < (IW + 1)'(wht_pkg::SAMPLES))
    else $error("ring index out of range");

endmodule

// ----- rtl/wht_ctrl.sv -----
// Sequencer: takes a request, runs averaging and control steps in operating mode as due, hands off the result.
module wht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wht_pkg::status_t sts_i,
  output wht_pkg::cmd_t    cmd_o
);

  localparam int IW = wht_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUM,
    S_MUL,
    S_FIX,
    S_CTRL,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.sum_idx = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.evt_load = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts_i.oper) begin
          state_d = S_DONE;
        end else if (sts_i.avg_due) begin
          cmd_o.sum_clr = 1'b1;
          cnt_d         = '0;
          state_d       = S_SUM;
        end else begin
          state_d = S_CTRL;
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (cnt_q == IW'(wht_pkg::SAMPLES - 1)) begin
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_MUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = S_FIX;
      end
      S_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = S_CTRL;
      end
      S_CTRL: begin
        cmd_o.ctrl_apply = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISPATCH && !in_ready_o)
    else $error("request accepted without starting work");

  a_sum_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> (IW + 1)'(cnt_q) < (IW + 1)'(wht_pkg::SAMPLES))
    else $error("ring sum index out of range");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not posted");

endmodule
